[rtl/assert_macros.svh]
// ============================================================================
// assert_macros.svh
// Assertion wrappers for the RTL; they compile away for synthesis.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// clocked check, held off while reset is asserted (active-low reset)
`define TWSM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// clocked check, also active during reset
`define TWSM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TWSM_ASSERT(lbl, clk, rst_n, prop, msg)
`define TWSM_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

[rtl/twsm_pkg.sv]
// ============================================================================
// twsm_pkg
// Shared types and constants of the two-wire sensor measurement master.
// ============================================================================
package twsm_pkg;

    // operation codes of an input transaction
    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_START = 2'd1,
        OP_RESET = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    // sensor commands
    localparam logic [7:0] CMD_TEMP = 8'h03;
    localparam logic [7:0] CMD_HUMI = 8'h05;

    // start condition pin pattern, bit k is phase k
    localparam int unsigned START_LEN = 7;
    localparam logic [START_LEN-1:0] START_SCK = 7'b0110110;
    localparam logic [START_LEN-1:0] START_DAT = 7'b1100011;

    // configuration register map
    localparam int unsigned   APB_AW        = 3;
    localparam logic [0:0]    REG_TIMEOUT   = 1'b0;
    localparam logic [15:0]   TIMEOUT_RESET = 16'hFFFF;

    // one input transaction
    typedef struct packed {
        t_op  op;
        logic measure_humidity;
        logic data_in;
    } t_item;

    // one result transaction
    typedef struct packed {
        logic        clock_out;
        logic        data_release;
        logic        busy_res;
        logic        done_res;
        logic [15:0] measured_value;
        logic [7:0]  checksum;
        logic [1:0]  error_count;
    } t_result;

endpackage

[rtl/twsm_in_if.sv]
// ============================================================================
// twsm_in_if
// Input channel: one pin phase request per transaction.
// ============================================================================
interface twsm_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] op;
    logic       measure_humidity;
    logic       data_in;

    modport source (output valid, output op, output measure_humidity,
                    output data_in, input ready);
    modport sink   (input valid, input op, input measure_humidity,
                    input data_in, output ready);
endinterface

[rtl/twsm_out_if.sv]
// ============================================================================
// twsm_out_if
// Result channel: pin levels and measurement status per transaction.
// ============================================================================
interface twsm_out_if;
    logic        valid;
    logic        ready;
    logic        clock_out;
    logic        data_release;
    logic        busy_res;
    logic        done_res;
    logic [15:0] measured_value;
    logic [7:0]  checksum;
    logic [1:0]  error_count;

    modport source (output valid, output clock_out, output data_release,
                    output busy_res, output done_res, output measured_value,
                    output checksum, output error_count, input ready);
    modport sink   (input valid, input clock_out, input data_release,
                    input busy_res, input done_res, input measured_value,
                    input checksum, input error_count, output ready);
endinterface

[rtl/two_wire_sensor_measurement_master_unit.sv]
// A transaction taken into the input register moves on into the result register
// once that register is empty or being read by the sink; it waits there otherwise.
// Throughput: one transaction per cycle unless the sink stalls; the sequencer steps once per phase.
// Reset (i_rst_n low, synchronous): pipeline empty, sequencer idle, value,
// checksum and error count zero, timeout register 65535. No clearing pass.
// ============================================================================
// two_wire_sensor_measurement_master_unit
// Top level: input register, sequencer step, result register, APB config.
// ============================================================================
`include "assert_macros.svh"

module two_wire_sensor_measurement_master_unit
    import twsm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    twsm_in_if.sink           i_in,
    twsm_out_if.source        o_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic        r_in_valid;
    t_item       r_in;
    logic        r_out_valid;
    t_result     r_out;
    t_result     step_result;
    logic        adv;
    logic        in_take;
    logic [15:0] timeout;

    assign adv     = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || adv;
    assign in_take = i_in.valid && i_in.ready;

    // configuration registers
    twsm_apb_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_timeout (timeout)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= in_take || (r_in_valid && !adv);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in.op               <= t_op'(i_in.op);
            r_in.measure_humidity <= i_in.measure_humidity;
            r_in.data_in          <= i_in.data_in;
        end
    end

    // sequencer
    twsm_seq u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (adv),
        .i_item    (r_in),
        .i_timeout (timeout),
        .o_result  (step_result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= adv || (r_out_valid && !o_out.ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= step_result;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.clock_out      = r_out.clock_out;
    assign o_out.data_release   = r_out.data_release;
    assign o_out.busy_res       = r_out.busy_res;
    assign o_out.done_res       = r_out.done_res;
    assign o_out.measured_value = r_out.measured_value;
    assign o_out.checksum       = r_out.checksum;
    assign o_out.error_count    = r_out.error_count;

    // checks
    `TWSM_ASSERT(a_done_not_busy, i_clk, i_rst_n, r_out_valid && r_out.done_res |-> !r_out.busy_res, "done transaction marked busy")
    `TWSM_ASSERT(a_step_fills_out, i_clk, i_rst_n, adv |=> r_out_valid, "stepped transaction lost before result register")
    `TWSM_ASSERT(a_in_held, i_clk, i_rst_n, r_in_valid && !adv |=> r_in_valid, "stalled input transaction dropped")
    `TWSM_ASSERT(a_err_sat, i_clk, i_rst_n, r_out_valid |-> r_out.error_count != 2'd3, "error count past saturation")

endmodule

[rtl/twsm_apb_regs.sv]
// ============================================================================
// twsm_apb_regs
// APB register file holding the DATA-low wait timeout.
// ============================================================================
module twsm_apb_regs
    import twsm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output logic [15:0]       o_timeout
);

    logic [15:0] r_timeout;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[APB_AW-1] == REG_TIMEOUT);

    // timeout register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RESET;
        end else if (wr_en) begin
            r_timeout <= pwdata[15:0];
        end
    end

    // readback
    always_comb begin
        prdata = 32'd0;
        if (paddr[APB_AW-1] == REG_TIMEOUT) begin
            prdata = {16'd0, r_timeout};
        end
    end

    assign o_timeout = r_timeout;

endmodule

[rtl/twsm_seq.sv]
// ============================================================================
// twsm_seq
// Bus sequencer: state registers and the one-phase step logic.
// ============================================================================
module twsm_seq
    import twsm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_step,
    input  t_item       i_item,
    input  logic [15:0] i_timeout,
    output t_result     o_result
);

    typedef enum logic [3:0] {
        PH_IDLE, PH_START, PH_WR_SET, PH_WR_HI, PH_ACK_SET, PH_ACK_HI, PH_WAIT,
        PH_RD_LO, PH_RD_HI, PH_RA_SET, PH_RA_HI, PH_DONE, PH_RST_HI, PH_RST_LO,
        PH_RSTART
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [3:0]  r_bit_idx, n_bit_idx;
    logic [7:0]  r_shift, n_shift;
    logic [15:0] r_value, n_value;
    logic [7:0]  r_checksum, n_checksum;
    logic [1:0]  r_errors, n_errors;
    logic [15:0] r_wait, n_wait;
    logic [1:0]  r_byte_idx, n_byte_idx;
    logic        r_humidity, n_humidity;

    // state as seen after an op is taken in idle
    t_phase      e_phase;
    logic [3:0]  e_bit_idx;
    logic [1:0]  e_errors;
    logic [15:0] e_wait;
    logic [1:0]  e_byte_idx;
    logic        e_humidity;

    logic [2:0]  start_k;
    logic [1:0]  err_sat;
    logic [15:0] wait_inc;
    logic [7:0]  rd_shift;
    logic        sck, rel, busy, done;

    // op decode: only idle takes a new sequence
    always_comb begin
        e_phase    = r_phase;
        e_bit_idx  = r_bit_idx;
        e_errors   = r_errors;
        e_wait     = r_wait;
        e_byte_idx = r_byte_idx;
        e_humidity = r_humidity;
        if (r_phase == PH_IDLE) begin
            if (i_item.op == OP_START) begin
                e_humidity = i_item.measure_humidity;
                e_errors   = 2'd0;
                e_wait     = 16'd0;
                e_byte_idx = 2'd0;
                e_bit_idx  = 4'd0;
                e_phase    = PH_START;
            end else if (i_item.op == OP_RESET) begin
                e_bit_idx = 4'd0;
                e_phase   = PH_RST_HI;
            end
        end
    end

    assign start_k  = (e_bit_idx < 4'd7) ? e_bit_idx[2:0] : 3'd6;
    assign err_sat  = (e_errors < 2'd2) ? e_errors + 2'd1 : e_errors;
    assign wait_inc = e_wait + 16'd1;
    assign rd_shift = {r_shift[6:0], i_item.data_in};

    // one pin phase
    always_comb begin
        n_phase    = e_phase;
        n_bit_idx  = e_bit_idx;
        n_shift    = r_shift;
        n_value    = r_value;
        n_checksum = r_checksum;
        n_errors   = e_errors;
        n_wait     = e_wait;
        n_byte_idx = e_byte_idx;
        n_humidity = e_humidity;
        sck  = 1'b0;
        rel  = 1'b1;
        done = 1'b0;
        busy = (e_phase != PH_IDLE) && (e_phase != PH_DONE);
        case (e_phase)
            PH_IDLE: begin
            end
            PH_START, PH_RSTART: begin
                sck = START_SCK[start_k];
                rel = START_DAT[start_k];
                if (start_k == 3'd6) begin
                    n_bit_idx = 4'd0;
                    if (e_phase == PH_START) begin
                        n_shift = e_humidity ? CMD_HUMI : CMD_TEMP;
                        n_phase = PH_WR_SET;
                    end else begin
                        n_phase = PH_IDLE;
                    end
                end else begin
                    n_bit_idx = {1'b0, start_k} + 4'd1;
                end
            end
            PH_WR_SET: begin
                rel     = r_shift[7];
                n_phase = PH_WR_HI;
            end
            PH_WR_HI: begin
                sck     = 1'b1;
                rel     = r_shift[7];
                n_shift = {r_shift[6:0], 1'b0};
                if (e_bit_idx >= 4'd7) begin
                    n_bit_idx = 4'd0;
                    n_phase   = PH_ACK_SET;
                end else begin
                    n_bit_idx = e_bit_idx + 4'd1;
                    n_phase   = PH_WR_SET;
                end
            end
            PH_ACK_SET: begin
                n_phase = PH_ACK_HI;
            end
            PH_ACK_HI: begin
                sck = 1'b1;
                if (i_item.data_in) begin
                    n_errors = err_sat;
                end
                n_wait  = 16'd0;
                n_phase = PH_WAIT;
            end
            PH_WAIT: begin
                // sensor pulls DATA low when conversion is finished
                if (!i_item.data_in) begin
                    n_phase = PH_RD_LO;
                end else begin
                    n_wait = wait_inc;
                    if (wait_inc >= i_timeout) begin
                        n_errors = err_sat;
                        n_phase  = PH_RD_LO;
                    end
                end
                if (n_phase == PH_RD_LO) begin
                    n_byte_idx = 2'd0;
                    n_bit_idx  = 4'd0;
                    n_shift    = 8'd0;
                end
            end
            PH_RD_LO: begin
                n_phase = PH_RD_HI;
            end
            PH_RD_HI: begin
                sck     = 1'b1;
                n_shift = rd_shift;
                if (e_bit_idx >= 4'd7) begin
                    n_bit_idx = 4'd0;
                    if (e_byte_idx == 2'd0) begin
                        n_value = {rd_shift, r_value[7:0]};
                    end else if (e_byte_idx == 2'd1) begin
                        n_value = {r_value[15:8], rd_shift};
                    end else begin
                        n_checksum = rd_shift;
                    end
                    n_phase = PH_RA_SET;
                end else begin
                    n_bit_idx = e_bit_idx + 4'd1;
                    n_phase   = PH_RD_LO;
                end
            end
            PH_RA_SET: begin
                // ack the first two bytes, leave the checksum unacked
                rel     = (e_byte_idx >= 2'd2);
                n_phase = PH_RA_HI;
            end
            PH_RA_HI: begin
                sck = 1'b1;
                rel = (e_byte_idx >= 2'd2);
                if (e_byte_idx >= 2'd2) begin
                    n_phase = PH_DONE;
                end else begin
                    n_byte_idx = e_byte_idx + 2'd1;
                    n_bit_idx  = 4'd0;
                    n_shift    = 8'd0;
                    n_phase    = PH_RD_LO;
                end
            end
            PH_DONE: begin
                done    = 1'b1;
                n_phase = PH_IDLE;
            end
            PH_RST_HI: begin
                sck     = 1'b1;
                n_phase = PH_RST_LO;
            end
            PH_RST_LO: begin
                if (e_bit_idx >= 4'd8) begin
                    n_bit_idx = 4'd0;
                    n_phase   = PH_RSTART;
                end else begin
                    n_bit_idx = e_bit_idx + 4'd1;
                    n_phase   = PH_RST_HI;
                end
            end
            default: begin
                n_phase = PH_IDLE;
                busy    = 1'b0;
            end
        endcase
    end

    // state registers advance once per transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_bit_idx  <= 4'd0;
            r_shift    <= 8'd0;
            r_value    <= 16'd0;
            r_checksum <= 8'd0;
            r_errors   <= 2'd0;
            r_wait     <= 16'd0;
            r_byte_idx <= 2'd0;
            r_humidity <= 1'b0;
        end else if (i_step) begin
            r_phase    <= n_phase;
            r_bit_idx  <= n_bit_idx;
            r_shift    <= n_shift;
            r_value    <= n_value;
            r_checksum <= n_checksum;
            r_errors   <= n_errors;
            r_wait     <= n_wait;
            r_byte_idx <= n_byte_idx;
            r_humidity <= n_humidity;
        end
    end

    // result of this phase
    always_comb begin
        o_result.clock_out      = sck;
        o_result.data_release   = rel;
        o_result.busy_res       = busy;
        o_result.done_res       = done;
        o_result.measured_value = n_value;
        o_result.checksum       = n_checksum;
        o_result.error_count    = n_errors;
    end

endmodule

[bench/tb_two_wire_sensor_measurement_master_unit.sv]
`timescale 1ns / 1ps
// ============================================================================
// tb_two_wire_sensor_measurement_master_unit
// Self-checking bench for the two-wire sensor measurement master. One result
// transaction is predicted for every input transaction and is compared field
// by field. Directed tests cover idle ticks, connection reset, measurements
// and the timeout register. A backpressure test and three randomized phases
// with different idling on both channels follow.
// ============================================================================
module tb_two_wire_sensor_measurement_master_unit;
    import twsm_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 5000;
    localparam int unsigned LONG_HOLD      = 300;
    localparam int unsigned RANDOM_ITEMS   = 200;
    localparam int unsigned MAX_REPORTS    = 10;
    localparam int unsigned DRAIN_CYCLES   = 8;
    localparam logic [APB_AW-1:0] TIMEOUT_ADDR = APB_AW'({REG_TIMEOUT, 2'b00});

    // sequencer phases as the bench tracks them
    typedef enum logic [3:0] {
        SQ_IDLE, SQ_START, SQ_WR_SET, SQ_WR_HI, SQ_ACK_SET, SQ_ACK_HI, SQ_WAIT,
        SQ_RD_LO, SQ_RD_HI, SQ_RA_SET, SQ_RA_HI, SQ_DONE, SQ_RST_HI, SQ_RST_LO,
        SQ_RSTART
    } t_seq;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [APB_AW-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    twsm_in_if  in_if();
    twsm_out_if out_if();

    two_wire_sensor_measurement_master_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // predicted sequencer state
    t_seq        seq;
    logic [3:0]  bit_idx;
    logic [7:0]  shifter;
    logic [15:0] value_q;
    logic [7:0]  csum_q;
    logic [1:0]  errs;
    logic [15:0] wait_cnt;
    logic [1:0]  byte_idx;
    logic        humi_q;
    logic [15:0] timeout_cfg;

    t_result     pin_results[$];
    int unsigned fail_count;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned hold_request;
    int unsigned hold_left;
    int unsigned idle_cycles;
    int unsigned items_sent;
    logic        offering;

    always #2 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------------
    task automatic clear_sequencer();
        seq         = SQ_IDLE;
        bit_idx     = '0;
        shifter     = '0;
        value_q     = '0;
        csum_q      = '0;
        errs        = '0;
        wait_cnt    = '0;
        byte_idx    = '0;
        humi_q      = 1'b0;
        timeout_cfg = TIMEOUT_RESET;
    endtask

    function automatic void count_error();
        if (errs < 2'd2) errs = errs + 2'd1;
    endfunction

    // advance one pin phase and return the pin levels and status it shows
    function automatic t_result step_pin_phase(input t_item it);
        t_result     r;
        logic        sck;
        logic        rel;
        logic        done;
        logic        busy;
        int unsigned k;
        t_seq        ph;
        sck  = 1'b0;
        rel  = 1'b1;
        done = 1'b0;
        if (seq == SQ_IDLE) begin
            if (it.op == OP_START) begin
                humi_q   = it.measure_humidity;
                errs     = '0;
                wait_cnt = '0;
                byte_idx = '0;
                bit_idx  = '0;
                seq      = SQ_START;
            end else if (it.op == OP_RESET) begin
                bit_idx = '0;
                seq     = SQ_RST_HI;
            end
        end
        ph   = seq;
        busy = (ph != SQ_IDLE) && (ph != SQ_DONE);
        case (ph)
            SQ_START, SQ_RSTART: begin
                k   = (bit_idx < START_LEN) ? bit_idx : START_LEN - 1;
                sck = START_SCK[k];
                rel = START_DAT[k];
                if (k >= START_LEN - 1) begin
                    bit_idx = '0;
                    if (ph == SQ_START) begin
                        shifter = humi_q ? CMD_HUMI : CMD_TEMP;
                        seq     = SQ_WR_SET;
                    end else begin
                        seq = SQ_IDLE;
                    end
                end else begin
                    bit_idx = 4'(k + 1);
                end
            end
            SQ_WR_SET: begin
                rel = shifter[7];
                seq = SQ_WR_HI;
            end
            SQ_WR_HI: begin
                sck     = 1'b1;
                rel     = shifter[7];
                shifter = {shifter[6:0], 1'b0};
                if (bit_idx >= 4'd7) begin
                    bit_idx = '0;
                    seq     = SQ_ACK_SET;
                end else begin
                    bit_idx = bit_idx + 4'd1;
                    seq     = SQ_WR_SET;
                end
            end
            SQ_ACK_SET: seq = SQ_ACK_HI;
            SQ_ACK_HI: begin
                sck = 1'b1;
                if (it.data_in) count_error();
                wait_cnt = '0;
                seq      = SQ_WAIT;
            end
            SQ_WAIT: begin
                if (!it.data_in) begin
                    seq = SQ_RD_LO;
                end else begin
                    wait_cnt = wait_cnt + 16'd1;
                    if (wait_cnt >= timeout_cfg) begin
                        count_error();
                        seq = SQ_RD_LO;
                    end
                end
                if (seq == SQ_RD_LO) begin
                    byte_idx = '0;
                    bit_idx  = '0;
                    shifter  = '0;
                end
            end
            SQ_RD_LO: seq = SQ_RD_HI;
            SQ_RD_HI: begin
                sck     = 1'b1;
                shifter = {shifter[6:0], it.data_in};
                if (bit_idx >= 4'd7) begin
                    bit_idx = '0;
                    if (byte_idx == 2'd0) value_q[15:8] = shifter;
                    else if (byte_idx == 2'd1) value_q[7:0] = shifter;
                    else csum_q = shifter;
                    seq = SQ_RA_SET;
                end else begin
                    bit_idx = bit_idx + 4'd1;
                    seq     = SQ_RD_LO;
                end
            end
            SQ_RA_SET: begin
                rel = (byte_idx >= 2'd2);
                seq = SQ_RA_HI;
            end
            SQ_RA_HI: begin
                sck = 1'b1;
                rel = (byte_idx >= 2'd2);
                if (byte_idx >= 2'd2) begin
                    seq = SQ_DONE;
                end else begin
                    byte_idx = byte_idx + 2'd1;
                    bit_idx  = '0;
                    shifter  = '0;
                    seq      = SQ_RD_LO;
                end
            end
            SQ_DONE: begin
                done = 1'b1;
                seq  = SQ_IDLE;
            end
            SQ_RST_HI: begin
                sck = 1'b1;
                seq = SQ_RST_LO;
            end
            SQ_RST_LO: begin
                if (bit_idx >= 4'd8) begin
                    bit_idx = '0;
                    seq     = SQ_RSTART;
                end else begin
                    bit_idx = bit_idx + 4'd1;
                    seq     = SQ_RST_HI;
                end
            end
            default: begin
                seq  = SQ_IDLE;
                busy = 1'b0;
            end
        endcase
        r.clock_out      = sck;
        r.data_release   = rel;
        r.busy_res       = busy;
        r.done_res       = done;
        r.measured_value = value_q;
        r.checksum       = csum_q;
        r.error_count    = errs;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------------
    // offer one transaction; predict it once it is accepted
    task automatic send_item(input t_item it);
        if ($urandom_range(99) < send_idle_pct) begin
            if (offering) in_if.valid <= 1'b0;
            offering = 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        in_if.valid            <= 1'b1;
        in_if.op               <= it.op;
        in_if.measure_humidity <= it.measure_humidity;
        in_if.data_in          <= it.data_in;
        offering = 1'b1;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        pin_results.push_back(step_pin_phase(it));
        items_sent++;
    endtask

    // stop offering and wait until every predicted result has come back
    task automatic wait_for_results();
        if (offering) in_if.valid <= 1'b0;
        offering = 1'b0;
        while (pin_results.size() != 0) @(posedge i_clk);
    endtask

    // op while busy is replaced by a random code at the given rate
    function automatic t_op busy_op(input int unsigned noise_pct);
        return ($urandom_range(99) < noise_pct) ? t_op'($urandom_range(3)) : OP_TICK;
    endfunction

    // one full measurement with the sensor answering as given
    task automatic run_measurement(input logic humi, input logic ack_level,
                                   input int unsigned wait_high,
                                   input logic [23:0] payload,
                                   input int unsigned noise_pct);
        t_item it;
        int    pos;
        it.op               = OP_START;
        it.measure_humidity = humi;
        it.data_in          = 1'($urandom_range(1));
        send_item(it);
        while (seq != SQ_IDLE) begin
            it.op               = busy_op(noise_pct);
            it.measure_humidity = 1'($urandom_range(1));
            case (seq)
                SQ_ACK_SET, SQ_ACK_HI: it.data_in = ack_level;
                SQ_WAIT:               it.data_in = (wait_cnt < wait_high);
                SQ_RD_LO, SQ_RD_HI: begin
                    pos        = 23 - 8 * int'(byte_idx) - int'(bit_idx);
                    it.data_in = payload[pos];
                end
                default:               it.data_in = 1'($urandom_range(1));
            endcase
            send_item(it);
        end
    endtask

    task automatic run_connection_reset(input int unsigned noise_pct);
        t_item it;
        it.op               = OP_RESET;
        it.measure_humidity = 1'($urandom_range(1));
        it.data_in          = 1'($urandom_range(1));
        send_item(it);
        while (seq != SQ_IDLE) begin
            it.op               = busy_op(noise_pct);
            it.measure_humidity = 1'($urandom_range(1));
            it.data_in          = 1'($urandom_range(1));
            send_item(it);
        end
    endtask

    // unstructured transactions, may leave a sequence half done
    task automatic run_noise(input int unsigned count);
        t_item it;
        repeat (count) begin
            it.op               = t_op'($urandom_range(3));
            it.measure_humidity = 1'($urandom_range(1));
            it.data_in          = 1'($urandom_range(1));
            send_item(it);
        end
    endtask

    task automatic send_tick(input t_op op, input logic humi, input logic din);
        t_item it;
        it.op               = op;
        it.measure_humidity = humi;
        it.data_in          = din;
        send_item(it);
    endtask

    // ------------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------------
    task automatic apb_access(input logic wr, input logic [15:0] wdata,
                              output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= TIMEOUT_ADDR;
        pwdata  <= {16'h0000, wdata};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic check_timeout_readback();
        logic [31:0] rdata;
        apb_access(1'b0, 16'h0000, rdata);
        compare_field("timeout_ticks", timeout_cfg, rdata[15:0]);
    endtask

    // only written with the sequencer idle and all results in
    task automatic write_timeout(input logic [15:0] ticks);
        logic [31:0] rdata;
        while (seq != SQ_IDLE) send_tick(OP_TICK, 1'b0, 1'($urandom_range(1)));
        wait_for_results();
        apb_access(1'b1, ticks, rdata);
        timeout_cfg = ticks;
        check_timeout_readback();
    endtask

    // ------------------------------------------------------------------------
    // result side: checking and ready generation
    // ------------------------------------------------------------------------
    task automatic compare_field(input string field, input logic [15:0] want,
                                 input logic [15:0] got);
        if (got !== want) begin
            if (fail_count < MAX_REPORTS)
                $display("mismatch in %s: expected %0h, got %0h", field, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
            if (pin_results.size() == 0) begin
                if (fail_count < MAX_REPORTS) $display("result with nothing expected");
                fail_count++;
            end else begin
                want = pin_results.pop_front();
                compare_field("clock_out", 16'(want.clock_out), 16'(out_if.clock_out));
                compare_field("data_release", 16'(want.data_release),
                              16'(out_if.data_release));
                compare_field("busy_res", 16'(want.busy_res), 16'(out_if.busy_res));
                compare_field("done_res", 16'(want.done_res), 16'(out_if.done_res));
                compare_field("measured_value", want.measured_value,
                              out_if.measured_value);
                compare_field("checksum", 16'(want.checksum), 16'(out_if.checksum));
                compare_field("error_count", 16'(want.error_count),
                              16'(out_if.error_count));
            end
        end
        // a long hold-off overrides the random stalls
        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // watchdog: cycles without a transaction on either channel
    always @(posedge i_clk) begin
        if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
            (out_if.valid === 1'b1 && out_if.ready === 1'b1)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("tb_two_wire_sensor_measurement_master_unit NOT OK");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_register_reset();
        check_timeout_readback();
    endtask

    // idle ticks and the unused op code leave the pins parked
    task automatic test_idle_ticks();
        send_tick(OP_TICK, 1'b0, 1'b0);
        send_tick(OP_TICK, 1'b1, 1'b1);
        send_tick(OP_NONE, 1'b1, 1'b0);
        send_tick(OP_NONE, 1'b0, 1'b1);
        wait_for_results();
    endtask

    // clock pulses on SCK plus start condition, with ops thrown in while busy
    task automatic test_connection_reset();
        run_connection_reset(0);
        run_connection_reset(50);
        wait_for_results();
    endtask

    task automatic test_measurements();
        run_measurement(1'b1, 1'b0, 0, 24'hFFFFFF, 0);
        run_measurement(1'b0, 1'b0, 3, 24'h000000, 0);
        run_measurement(1'b1, 1'b1, 2, 24'hA55AC3, 30);
        run_measurement(1'b0, 1'b0, 1, 24'h5AA53C, 0);
        wait_for_results();
    endtask

    // wait limit at its reset value, zero, one and a mid value
    task automatic test_timeout_register();
        run_measurement(1'b0, 1'b1, 6, 24'h123456, 0);
        write_timeout(16'd0);
        run_measurement(1'b1, 1'b0, 3, 24'h89ABCD, 0);
        run_measurement(1'b0, 1'b0, 0, 24'hEF0123, 0);
        write_timeout(16'd1);
        run_measurement(1'b1, 1'b0, 1, 24'h0F0F0F, 0);
        run_measurement(1'b0, 1'b0, 0, 24'hF0F0F0, 0);
        write_timeout(16'd3);
        run_measurement(1'b1, 1'b0, 2, 24'h336699, 0);
        run_measurement(1'b0, 1'b1, 3, 24'hCC9966, 0);
        write_timeout(TIMEOUT_RESET);
        wait_for_results();
    endtask

    // result side blocked for a long stretch while input keeps coming
    task automatic test_backpressure();
        wait_for_results();
        hold_request = LONG_HOLD;
        run_measurement(1'b1, 1'b0, 2, 24'($urandom()), 0);
        wait_for_results();
    endtask

    task automatic test_random(input int unsigned sender_pct,
                               input int unsigned receiver_pct,
                               input logic [15:0] ticks);
        int unsigned target;
        int unsigned pick;
        int unsigned wait_high;
        write_timeout(ticks);
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
                wait_high = ($urandom_range(99) < 80) ? $urandom_range(0, 4)
                                                      : $urandom_range(0, 40);
                run_measurement(1'($urandom_range(1)), ($urandom_range(99) < 15),
                                wait_high, 24'($urandom()), 10);
            end else if (pick < 80) begin
                run_connection_reset(10);
            end else begin
                run_noise($urandom_range(5, 20));
            end
        end
        wait_for_results();
    endtask

    initial begin
        i_clk                  = 1'b0;
        i_rst_n                = 1'b0;
        in_if.valid            = 1'b0;
        in_if.op               = OP_TICK;
        in_if.measure_humidity = 1'b0;
        in_if.data_in          = 1'b0;
        out_if.ready           = 1'b0;
        psel                   = 1'b0;
        penable                = 1'b0;
        pwrite                 = 1'b0;
        paddr                  = '0;
        pwdata                 = '0;
        fail_count             = 0;
        send_idle_pct          = 0;
        recv_idle_pct          = 0;
        hold_request           = 0;
        hold_left              = 0;
        idle_cycles            = 0;
        items_sent             = 0;
        offering               = 1'b0;
        clear_sequencer();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_register_reset();
        test_idle_ticks();
        test_connection_reset();
        test_measurements();
        test_timeout_register();
        test_backpressure();
        test_random(30, 62, 16'($urandom_range(1, 8)));
        test_random(62, 30, TIMEOUT_RESET);
        test_random(0, 0, 16'($urandom_range(1, 20)));

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb_two_wire_sensor_measurement_master_unit OK");
        end else begin
            $display("tb_two_wire_sensor_measurement_master_unit NOT OK");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+rtl
rtl/twsm_pkg.sv
rtl/twsm_in_if.sv
rtl/twsm_out_if.sv
rtl/twsm_apb_regs.sv
rtl/twsm_seq.sv
rtl/two_wire_sensor_measurement_master_unit.sv
bench/tb_two_wire_sensor_measurement_master_unit.sv
